>>> design/assert_macros.svh
// assert_macros.svh: shorthand for the concurrent assertions of the checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define FCCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define FCCT_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/fcct_pkg.sv
// fcct_pkg: types, constants and microcode word layout of the cluster chain table.
// No dependencies; used by every other file of the block but fcct_ram and assert_macros.svh.
package fcct_pkg;

    localparam int LINK_W            = 28;
    localparam int COUNT_W           = 12;
    localparam int DEF_TABLE_ENTRIES = 4096;

    typedef logic [LINK_W-1:0] t_link;

    localparam t_link             LINK_MASK    = 28'hFFF_FFFF;
    localparam t_link             END_OF_CHAIN = 28'hFFF_FFF8;
    localparam t_link             FIRST_DATA   = 28'd2;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 12'd4094;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_ALLOC = 2'd2,
        MODE_FREE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LONG  = 2'd3
    } t_status;

    // microcode step addresses
    typedef enum logic [4:0] {
        U_CLR, U_IDLE,
        U_RD0, U_RD1,
        U_WR0, U_WR1,
        U_AL0, U_AL1, U_AL2, U_AL3, U_AL4,
        U_FR0, U_FR1, U_FR2,
        U_RANGE, U_FULL, U_LONG,
        U_EMIT
    } t_upc;

    // branch conditions
    typedef enum logic [3:0] {
        C_NONE, C_CLR_MORE, C_IDX_OOR, C_PREV_BAD, C_PREV_ZERO,
        C_SCAN_DONE, C_DATA_ZERO, C_WALK_END, C_FREED_FULL, C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        CUR_HOLD, CUR_INC, CUR_FIRST, CUR_DATA
    } t_cur_op;

    typedef enum logic [2:0] {
        WR_NONE, WR_ZERO_CUR, WR_VAL_CUR, WR_EOC_RES, WR_RES_PREV
    } t_wr_op;

    typedef enum logic [1:0] {
        RES_HOLD, RES_DATA, RES_TAG, RES_ZERO
    } t_res_op;

    // datapath controls of one microcode word
    typedef struct packed {
        logic    accept;
        logic    push;
        t_cur_op cur_op;
        t_wr_op  wr_op;
        t_res_op res_op;
        logic    freed_inc;
        logic    set_status;
        t_status status;
    } t_ctl;

    // whole microcode word: controls plus two branch slots and a fall-through
    typedef struct packed {
        t_ctl  ctl;
        t_cond br1_cond;
        t_upc  br1_tgt;
        t_cond br2_cond;
        t_upc  br2_tgt;
        t_upc  next;
    } t_uword;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic clr_more;
        logic idx_oor;
        logic prev_bad;
        logic prev_zero;
        logic scan_done;
        logic data_zero;
        logic walk_end;
        logic freed_full;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        logic   accepted;
        t_mode  mode;
        t_flags flags;
    } t_dp_stat;

endpackage

>>> design/fcct_if.sv
// fcct_if: valid/ready channels of the cluster chain table (request, result, config).
// Depends on fcct_pkg for field types.
interface fcct_req_if import fcct_pkg::*; ();
    logic  valid;
    logic  ready;
    t_mode mode;
    t_link cluster_index;
    t_link entry_value;

    modport source (output valid, output mode, output cluster_index, output entry_value,
                    input ready);
    modport sink (input valid, input mode, input cluster_index, input entry_value,
                  output ready);
endinterface

interface fcct_rsp_if import fcct_pkg::*; ();
    logic    valid;
    logic    ready;
    t_link   result_value;
    t_status status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink (input valid, input result_value, input status, output ready);
endinterface

interface fcct_cfg_if import fcct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] cluster_count;

    modport source (output valid, output cluster_count, input ready);
    modport sink (input valid, input cluster_count, output ready);
endinterface

>>> design/fcct_ram.sv
// fcct_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcct_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/fcct_seq.sv
// fcct_seq: microcode ROM, step counter and branch logic of the cluster chain table.
// Depends on fcct_pkg; drives the controls of fcct_dp.
module fcct_seq import fcct_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_ctl     o_ctl
);
    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_word;

    // control store: one word per step
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        w.ctl.accept     = 1'b0;
        w.ctl.push       = 1'b0;
        w.ctl.cur_op     = CUR_HOLD;
        w.ctl.wr_op      = WR_NONE;
        w.ctl.res_op     = RES_HOLD;
        w.ctl.freed_inc  = 1'b0;
        w.ctl.set_status = 1'b0;
        w.ctl.status     = ST_OK;
        w.br1_cond       = C_NONE;
        w.br1_tgt        = U_IDLE;
        w.br2_cond       = C_NONE;
        w.br2_tgt        = U_IDLE;
        w.next           = U_IDLE;
        unique case (a)
            // clearing pass: zero one entry a step
            U_CLR: begin
                w.ctl.wr_op  = WR_ZERO_CUR;
                w.ctl.cur_op = CUR_INC;
                w.br1_cond   = C_CLR_MORE;
                w.br1_tgt    = U_CLR;
            end
            U_IDLE: begin
                w.ctl.accept = 1'b1;
            end
            // read entry
            U_RD0: begin
                w.br1_cond = C_IDX_OOR;
                w.br1_tgt  = U_RANGE;
                w.next     = U_RD1;
            end
            U_RD1: begin
                w.ctl.res_op = RES_DATA;
                w.next       = U_EMIT;
            end
            // write entry
            U_WR0: begin
                w.br1_cond = C_IDX_OOR;
                w.br1_tgt  = U_RANGE;
                w.next     = U_WR1;
            end
            U_WR1: begin
                w.ctl.wr_op = WR_VAL_CUR;
                w.next      = U_EMIT;
            end
            // allocate: check previous cluster, then scan from the first data cluster
            U_AL0: begin
                w.ctl.cur_op = CUR_FIRST;
                w.br1_cond   = C_PREV_BAD;
                w.br1_tgt    = U_RANGE;
                w.next       = U_AL1;
            end
            U_AL1: begin
                w.ctl.cur_op = CUR_INC;
                w.br1_cond   = C_SCAN_DONE;
                w.br1_tgt    = U_FULL;
                w.next       = U_AL2;
            end
            U_AL2: begin
                w.ctl.cur_op = CUR_INC;
                w.ctl.res_op = RES_TAG;
                w.br1_cond   = C_DATA_ZERO;
                w.br1_tgt    = U_AL3;
                w.br2_cond   = C_SCAN_DONE;
                w.br2_tgt    = U_FULL;
                w.next       = U_AL2;
            end
            U_AL3: begin
                w.ctl.wr_op = WR_EOC_RES;
                w.br1_cond  = C_PREV_ZERO;
                w.br1_tgt   = U_EMIT;
                w.next      = U_AL4;
            end
            U_AL4: begin
                w.ctl.wr_op = WR_RES_PREV;
                w.next      = U_EMIT;
            end
            // free: walk the chain, each entry through the three steps FR0, FR1 and FR2
            U_FR0: begin
                w.br1_cond = C_WALK_END;
                w.br1_tgt  = U_EMIT;
                w.br2_cond = C_IDX_OOR;
                w.br2_tgt  = U_RANGE;
                w.next     = U_FR1;
            end
            U_FR1: begin
                w.br1_cond = C_FREED_FULL;
                w.br1_tgt  = U_LONG;
                w.next     = U_FR2;
            end
            U_FR2: begin
                w.ctl.wr_op     = WR_ZERO_CUR;
                w.ctl.cur_op    = CUR_DATA;
                w.ctl.freed_inc = 1'b1;
                w.next          = U_FR0;
            end
            // error endings
            U_RANGE: begin
                w.ctl.set_status = 1'b1;
                w.ctl.status     = ST_RANGE;
                w.next           = U_EMIT;
            end
            U_FULL: begin
                w.ctl.set_status = 1'b1;
                w.ctl.status     = ST_FULL;
                w.ctl.res_op     = RES_ZERO;
                w.next           = U_EMIT;
            end
            U_LONG: begin
                w.ctl.set_status = 1'b1;
                w.ctl.status     = ST_LONG;
                w.next           = U_EMIT;
            end
            // hand the result to the output register, wait while it is full
            U_EMIT: begin
                w.ctl.push = 1'b1;
                w.br1_cond = C_OUT_BUSY;
                w.br1_tgt  = U_EMIT;
            end
            default: begin
                w.next = U_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic cond_true(input t_cond c, input t_flags f);
        logic hit;
        unique case (c)
            C_NONE:       hit = 1'b0;
            C_CLR_MORE:   hit = f.clr_more;
            C_IDX_OOR:    hit = f.idx_oor;
            C_PREV_BAD:   hit = f.prev_bad;
            C_PREV_ZERO:  hit = f.prev_zero;
            C_SCAN_DONE:  hit = f.scan_done;
            C_DATA_ZERO:  hit = f.data_zero;
            C_WALK_END:   hit = f.walk_end;
            C_FREED_FULL: hit = f.freed_full;
            C_OUT_BUSY:   hit = f.out_busy;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic t_upc entry_step(input t_mode m);
        t_upc s;
        unique case (m)
            MODE_READ:  s = U_RD0;
            MODE_WRITE: s = U_WR0;
            MODE_ALLOC: s = U_AL0;
            MODE_FREE:  s = U_FR0;
        endcase
        return s;
    endfunction

    always_comb begin
        w_word = ucode(r_upc);
    end

    assign o_ctl = w_word.ctl;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    // dispatch on a transfer, else first taken branch, else fall through
    always_comb begin
        if (w_word.ctl.accept && i_stat.accepted) begin
            n_upc = entry_step(i_stat.mode);
        end else if (cond_true(w_word.br1_cond, i_stat.flags)) begin
            n_upc = w_word.br1_tgt;
        end else if (cond_true(w_word.br2_cond, i_stat.flags)) begin
            n_upc = w_word.br2_tgt;
        end else begin
            n_upc = w_word.next;
        end
    end
endmodule

>>> design/fcct_dp.sv
// fcct_dp: datapath of the cluster chain table: working registers, table RAM,
// config register and output register. Depends on fcct_pkg, fcct_if, fcct_ram.
module fcct_dp import fcct_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    output t_dp_stat   o_stat,
    fcct_req_if.sink   i_req,
    fcct_rsp_if.source o_rsp,
    fcct_cfg_if.sink   i_cfg
);
    localparam int    AW        = $clog2(TABLE_ENTRIES);
    localparam int    FW        = $clog2(TABLE_ENTRIES + 1);
    localparam t_link ENTRIES_L = LINK_W'(TABLE_ENTRIES);
    localparam t_link LAST_L    = LINK_W'(TABLE_ENTRIES - 1);

    t_link              r_cur;
    t_link              r_prev;
    t_link              r_val;
    t_link              r_result;
    t_status            r_status;
    logic [AW-1:0]      r_tag;
    logic [FW-1:0]      r_freed;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_link              r_out_result;
    t_status            r_out_status;

    logic               w_accept;
    logic               w_out_free;
    logic               w_push;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_link              w_wdata;
    t_link              w_rdata;
    t_link              w_limit_sum;
    t_link              w_limit;

    // Only the 28-bit link field is stored: no request ever sets the reserved
    // nibble, so it stays zero and a kept nibble is always zero.
    fcct_ram #(
        .WIDTH (LINK_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // request handshake
    assign i_req.ready = i_ctl.accept;
    assign w_accept    = i_ctl.accept && i_req.valid;

    // config register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_count <= i_cfg.cluster_count;
        end
    end

    // scan limit: min(cluster_count + 2, table size)
    assign w_limit_sum = {{(LINK_W - COUNT_W){1'b0}}, r_count} + FIRST_DATA;
    assign w_limit     = (w_limit_sum > ENTRIES_L) ? ENTRIES_L : w_limit_sum;

    // table write port select
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_cur[AW-1:0];
        w_wdata = '0;
        unique case (i_ctl.wr_op)
            WR_NONE: begin
                w_we = 1'b0;
            end
            WR_ZERO_CUR: begin
                w_wdata = '0;
            end
            WR_VAL_CUR: begin
                w_wdata = r_val;
            end
            WR_EOC_RES: begin
                w_waddr = r_result[AW-1:0];
                w_wdata = LINK_MASK;
            end
            WR_RES_PREV: begin
                w_waddr = r_prev[AW-1:0];
                w_wdata = r_result;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // cursor and request registers; reset clears the cursor for the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (w_accept) begin
            r_cur <= i_req.cluster_index;
        end else begin
            case (i_ctl.cur_op)
                CUR_INC:   r_cur <= r_cur + 1'b1;
                CUR_FIRST: r_cur <= FIRST_DATA;
                CUR_DATA:  r_cur <= w_rdata;
                default:   r_cur <= r_cur;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev <= i_req.cluster_index;
            r_val  <= i_req.entry_value;
        end
    end

    // address of the entry whose data the RAM returns this cycle
    always_ff @(posedge i_clk) begin
        r_tag <= r_cur[AW-1:0];
    end

    // result, status and freed count
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= '0;
            r_status <= ST_OK;
            r_freed  <= '0;
        end else begin
            case (i_ctl.res_op)
                RES_DATA: r_result <= w_rdata;
                RES_TAG:  r_result <= {{(LINK_W - AW){1'b0}}, r_tag};
                RES_ZERO: r_result <= '0;
                default:  r_result <= r_result;
            endcase
            if (i_ctl.set_status) begin
                r_status <= i_ctl.status;
            end
            if (i_ctl.freed_inc) begin
                r_freed <= r_freed + 1'b1;
            end
        end
    end

    // output register: free when empty or drained this cycle
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_push     = i_ctl.push && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_result <= r_result;
            r_out_status <= r_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_result;
    assign o_rsp.status       = r_out_status;

    // conditions for the sequencer
    always_comb begin
        o_stat.accepted         = w_accept;
        o_stat.mode             = i_req.mode;
        o_stat.flags.clr_more   = (r_cur != LAST_L);
        o_stat.flags.idx_oor    = (r_cur >= ENTRIES_L);
        o_stat.flags.prev_bad   = (r_prev != '0) && (r_prev >= ENTRIES_L);
        o_stat.flags.prev_zero  = (r_prev == '0);
        o_stat.flags.scan_done  = (r_cur >= w_limit);
        o_stat.flags.data_zero  = (w_rdata == '0);
        o_stat.flags.walk_end   = (r_cur < FIRST_DATA) || (r_cur >= END_OF_CHAIN);
        o_stat.flags.freed_full = (r_freed == FW'(TABLE_ENTRIES));
        o_stat.flags.out_busy   = !w_out_free;
    end
endmodule

>>> design/fat_cluster_chain_table.sv
// fat_cluster_chain_table: cluster allocation table driven by a microcode sequencer.
// Read and write need no scan; allocate scans the table entry by entry from the first data cluster;
// free walks and clears the chain entry by entry (one table RAM port pair).
// The next request is taken in the cycle after its predecessor's result is registered.
// Synchronous active-low reset, then a clearing pass over all TABLE_ENTRIES entries, request not ready.
// Depends on fcct_pkg, fcct_if, fcct_seq, fcct_dp and fcct_ram.
module fat_cluster_chain_table import fcct_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcct_req_if.sink   i_req,
    fcct_rsp_if.source o_rsp,
    fcct_cfg_if.sink   i_cfg
);
    t_ctl     w_ctl;
    t_dp_stat w_stat;

    // sequencer
    fcct_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    // datapath
    fcct_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg)
    );
endmodule

>>> design/fcct_checker.sv
// fcct_checker: port-level assertions for fat_cluster_chain_table, bound to the top level.
// Depends on fcct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcct_checker import fcct_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input logic    i_rsp_valid,
    input logic    i_rsp_ready,
    input t_link   i_rsp_result,
    input t_status i_rsp_status
);
    // reset empties the output and starts the clearing pass
    `FCCT_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (!i_rsp_valid && !i_req_ready), "reset must empty the output and hold off requests")

    // one request at a time: no transfer right after a transfer
    `FCCT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready, "request taken while another is in work")

    // any error or disk full returns a zero result
    `FCCT_ASSERT(a_error_zero, i_clk, i_rst_n, (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_result == '0), "non-ok status with non-zero result")

    // a stalled result holds
    `FCCT_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_result) && $stable(i_rsp_status)), "stalled result changed")
endmodule

bind fat_cluster_chain_table fcct_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_result (o_rsp.result_value),
    .i_rsp_status (o_rsp.status)
);

>>> tb/fat_cluster_chain_table_test.sv
// fat_cluster_chain_table_test: self-checking bench for the FAT cluster chain table.
// Runs a directed table and random read/write/allocate/free traffic against a shadow table.
// Depends on fcct_pkg, fcct_if and the fat_cluster_chain_table RTL.
module fat_cluster_chain_table_test;
    import fcct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_ENTRIES    = DEF_TABLE_ENTRIES;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 10;

    typedef struct packed {
        t_link   value;
        t_status status;
    } t_due;

    typedef struct packed {
        t_mode   mode;
        t_link   index;
        t_link   value;
        logic    typed;
        t_link   res;
        t_status st;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fcct_req_if req_if ();
    fcct_rsp_if rsp_if ();
    fcct_cfg_if cfg_if ();

    fat_cluster_chain_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // shadow of the allocation table and the cluster count register
    logic [31:0]        fat_shadow [TBL_ENTRIES];
    logic [COUNT_W-1:0] count_shadow;

    t_due  due_results [$];
    t_link live_heads [$];
    int    err_count;
    int    items_sent;
    int    idle_cycles;
    int    stall_left;
    bit    req_calm;
    bit    rsp_calm;
    bit    hold_pending;

    // directed rows on a fresh table with the reset cluster count
    t_row directed_rows [27] = '{
        '{MODE_READ,  28'd0,        28'hFFF_FFFF, 1'b1, 28'd0,        ST_OK},
        '{MODE_READ,  28'd4095,     28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_READ,  28'd4096,     28'd0,        1'b1, 28'd0,        ST_RANGE},
        '{MODE_WRITE, 28'hFFF_FFFF, 28'hFFF_FFFF, 1'b1, 28'd0,        ST_RANGE},
        '{MODE_WRITE, 28'd4095,     28'hFFF_FFFF, 1'b1, 28'd0,        ST_OK},
        '{MODE_READ,  28'd4095,     28'd0,        1'b1, 28'hFFF_FFFF, ST_OK},
        '{MODE_ALLOC, 28'd0,        28'd0,        1'b1, 28'd2,        ST_OK},
        '{MODE_ALLOC, 28'd2,        28'hFFF_FFFF, 1'b1, 28'd3,        ST_OK},
        '{MODE_ALLOC, 28'd4096,     28'd0,        1'b1, 28'd0,        ST_RANGE},
        '{MODE_ALLOC, 28'hFFF_FFFF, 28'd0,        1'b1, 28'd0,        ST_RANGE},
        '{MODE_READ,  28'd2,        28'd0,        1'b1, 28'd3,        ST_OK},
        '{MODE_READ,  28'd3,        28'd0,        1'b1, 28'hFFF_FFFF, ST_OK},
        '{MODE_ALLOC, 28'd4,        28'd0,        1'b1, 28'd4,        ST_OK},
        '{MODE_READ,  28'd4,        28'd0,        1'b1, 28'd4,        ST_OK},
        '{MODE_FREE,  28'd4,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_FREE,  28'd2,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_READ,  28'd3,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_FREE,  28'd0,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_FREE,  28'd1,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_WRITE, 28'd5,        28'd4096,     1'b1, 28'd0,        ST_OK},
        '{MODE_FREE,  28'd5,        28'd0,        1'b1, 28'd0,        ST_RANGE},
        '{MODE_READ,  28'd5,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_WRITE, 28'd6,        28'hFFF_FFF8, 1'b1, 28'd0,        ST_OK},
        '{MODE_FREE,  28'd6,        28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_FREE,  28'hFFF_FFF7, 28'd0,        1'b1, 28'd0,        ST_RANGE},
        '{MODE_FREE,  28'hFFF_FFFF, 28'd0,        1'b1, 28'd0,        ST_OK},
        '{MODE_WRITE, 28'd7,        28'h555_5555, 1'b0, 28'd0,        ST_OK}
    };

    int count_plan [NUM_PHASES] = '{1, 4094, 0, 4095, 3, 24, 200, 0, 0, 4094};

    // clock, period 2 ns
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // apply one request to the shadow table and return the result it owes
    function automatic void fat_apply(input t_mode m, input t_link idx, input t_link val,
                                      output t_link res, output t_status st);
        int unsigned lim;
        int unsigned c;
        int unsigned freed;
        t_link       cur;
        t_link       nxt;
        res = '0;
        st  = ST_OK;
        case (m)
            MODE_READ: begin
                if (idx >= TBL_ENTRIES) st = ST_RANGE;
                else res = fat_shadow[idx][LINK_W-1:0];
            end
            MODE_WRITE: begin
                if (idx >= TBL_ENTRIES) st = ST_RANGE;
                else fat_shadow[idx][LINK_W-1:0] = val;
            end
            MODE_ALLOC: begin
                if (idx != '0 && idx >= TBL_ENTRIES) begin
                    st = ST_RANGE;
                end else begin
                    // scan stops at cluster_count + 2 or at the end of the table, whichever is lower
                    lim = int'(count_shadow) + int'(FIRST_DATA);
                    if (lim > TBL_ENTRIES) lim = TBL_ENTRIES;
                    c = FIRST_DATA;
                    while (c < lim && fat_shadow[c][LINK_W-1:0] != '0) c++;
                    if (c >= lim) begin
                        st = ST_FULL;
                    end else begin
                        // mark end of chain first, then link the previous cluster
                        fat_shadow[c][LINK_W-1:0] = LINK_MASK;
                        if (idx != '0) fat_shadow[idx][LINK_W-1:0] = t_link'(c);
                        res = t_link'(c);
                    end
                end
            end
            default: begin
                cur   = idx;
                freed = 0;
                while (cur >= FIRST_DATA && cur < END_OF_CHAIN) begin
                    if (cur >= TBL_ENTRIES) begin
                        st = ST_RANGE;
                        break;
                    end
                    if (freed >= TBL_ENTRIES) begin
                        st = ST_LONG;
                        break;
                    end
                    nxt = fat_shadow[cur][LINK_W-1:0];
                    fat_shadow[cur][LINK_W-1:0] = '0;
                    freed++;
                    cur = nxt;
                end
            end
        endcase
    endfunction

    // idle stretch length: mostly short, a few long
    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // cluster index: mostly near the active range, sometimes anywhere in 28 bits
    function automatic t_link pick_index();
        int hi;
        int r;
        hi = int'(count_shadow) + 3;
        if (hi > TBL_ENTRIES - 1) hi = TBL_ENTRIES - 1;
        r = $urandom_range(0, 99);
        if (r < 70) return t_link'($urandom_range(0, hi));
        if (r < 85) return t_link'($urandom_range(0, TBL_ENTRIES - 1));
        if (r < 95) return t_link'($urandom());
        case ($urandom_range(0, 3))
            0: return t_link'(TBL_ENTRIES);
            1: return t_link'(TBL_ENTRIES - 1);
            2: return '0;
            default: return LINK_MASK;
        endcase
    endfunction

    // link value: table links, end-of-chain markers, stop values and raw noise
    function automatic t_link pick_link();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return pick_index();
        if (r < 45) return END_OF_CHAIN + t_link'($urandom_range(0, 7));
        if (r < 55) return '0;
        if (r < 65) return t_link'(1);
        if (r < 85) return t_link'($urandom());
        return t_link'($urandom_range(2, TBL_ENTRIES - 1));
    endfunction

    // offer one request, predict its result at the transfer, then at times idle a while
    task automatic issue(input t_mode m, input t_link idx, input t_link val,
                         input logic typed, input t_link tres, input t_status tst,
                         output t_link got_res, output t_status got_st);
        int gap;
        req_if.valid         <= 1'b1;
        req_if.mode          <= m;
        req_if.cluster_index <= idx;
        req_if.entry_value   <= val;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        fat_apply(m, idx, val, got_res, got_st);
        if (typed) due_results.push_back('{tres, tst});
        else due_results.push_back('{got_res, got_st});
        items_sent++;
        gap = (req_calm || $urandom_range(0, 9) < 7) ? 0 : idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid, wait for every owed result, then let the pipeline drain
    task automatic quiesce();
        req_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the cluster count while the block is idle
    task automatic set_count(input logic [COUNT_W-1:0] cnt);
        cfg_if.valid         <= 1'b1;
        cfg_if.cluster_count <= cnt;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        count_shadow = cnt;
    endtask

    // random traffic, mostly chain building and freeing with random content
    task automatic run_random(input int n);
        int      first;
        int      pick;
        int      len;
        int      k;
        t_link   prev;
        t_link   head;
        t_link   got;
        t_status gst;
        first = items_sent;
        while (items_sent - first < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // build a chain, each new cluster linked from the last one
                k = $urandom_range(0, 39);
                len = (k == 0) ? $urandom_range(100, 160) :
                      (k < 5)  ? $urandom_range(8, 40) : $urandom_range(1, 6);
                prev = '0;
                head = '0;
                for (int i = 0; i < len; i++) begin
                    issue(MODE_ALLOC, prev, t_link'($urandom()), 1'b0, '0, ST_OK, got, gst);
                    if (gst != ST_OK) break;
                    if (head == '0) head = got;
                    prev = got;
                end
                if (head != '0) live_heads.push_back(head);
            end else if (pick < 55 && live_heads.size() != 0) begin
                k = $urandom_range(0, live_heads.size() - 1);
                head = live_heads[k];
                live_heads.delete(k);
                issue(MODE_FREE, head, t_link'($urandom()), 1'b0, '0, ST_OK, got, gst);
            end else if (pick < 70) begin
                issue(MODE_WRITE, pick_index(), pick_link(), 1'b0, '0, ST_OK, got, gst);
            end else if (pick < 85) begin
                head = (live_heads.size() != 0 && $urandom_range(0, 1) == 0) ?
                       live_heads[$urandom_range(0, live_heads.size() - 1)] : pick_index();
                issue(MODE_READ, head, t_link'($urandom()), 1'b0, '0, ST_OK, got, gst);
            end else if (pick < 92) begin
                issue(MODE_FREE, pick_index(), t_link'($urandom()), 1'b0, '0, ST_OK, got, gst);
            end else if (pick < 99) begin
                issue(MODE_ALLOC, pick_index(), t_link'($urandom()), 1'b0, '0, ST_OK,
                      got, gst);
            end else begin
                quiesce();
            end
        end
    endtask

    // check each result transfer against the oldest owed result; pace ready
    always @(posedge i_clk) begin
        t_due owed;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing owed: value %h status %0d", $time,
                         rsp_if.result_value, rsp_if.status);
            end else begin
                owed = due_results.pop_front();
                if (rsp_if.result_value !== owed.value) begin
                    err_count++;
                    $display("%0t: result_value mismatch, expected %h, got %h", $time,
                             owed.value, rsp_if.result_value);
                end
                if (rsp_if.status !== owed.status) begin
                    err_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             owed.status, rsp_if.status);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
        end else if (!rsp_calm && $urandom_range(0, 9) < 3) begin
            stall_left = idle_len() - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fat_cluster_chain_table_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_link   got;
        t_status gst;
        int      cnt;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_READ;
        req_if.cluster_index = '0;
        req_if.entry_value   = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.cluster_count = '0;
        rsp_if.ready         = 1'b0;
        err_count    = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        req_calm     = 1'b0;
        rsp_calm     = 1'b0;
        hold_pending = 1'b0;
        count_shadow = COUNT_RESET;
        foreach (fat_shadow[i]) fat_shadow[i] = '0;

        // hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table on the reset configuration
        foreach (directed_rows[r]) begin
            issue(directed_rows[r].mode, directed_rows[r].index, directed_rows[r].value,
                  directed_rows[r].typed, directed_rows[r].res, directed_rows[r].st,
                  got, gst);
        end
        issue(MODE_READ, 28'd7, '0, 1'b0, '0, ST_OK, got, gst);
        quiesce();

        // random phases over a spread of cluster counts
        for (int p = 0; p < NUM_PHASES; p++) begin
            cnt = (p == 7 || p == 8) ? $urandom_range(1, 4094) : count_plan[p];
            set_count(COUNT_W'(cnt));
            rsp_calm = (p == 4);
            req_calm = (p == 4 || p == 5);
            // receiver holds off long while the sender keeps offering
            if (p == 5) hold_pending = 1'b1;
            run_random(PHASE_ITEMS);
            quiesce();
        end

        if (err_count == 0 && due_results.size() == 0) begin
            $display("fat_cluster_chain_table_test: clean");
        end else begin
            $display("fat_cluster_chain_table_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/fcct_pkg.sv
design/fcct_if.sv
design/fcct_ram.sv
design/fcct_seq.sv
design/fcct_dp.sv
design/fat_cluster_chain_table.sv
design/fcct_checker.sv
tb/fat_cluster_chain_table_test.sv
